// File: sv/mcpwc_pkg.sv
// ----------------------------------------------------------------------------
// mcpwc_pkg: shared constants and types of the pulse width capture block
// pin numbering, register map and queue sizing used by all modules
// ----------------------------------------------------------------------------
package mcpwc_pkg;

  localparam int CHANNELS_DEF  = 8;
  localparam int TIME_BITS_DEF = 32;

  localparam int PIN_COUNT   = 40;
  localparam int PIN_W       = 6;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int REG_ADDR_W  = 5;
  localparam int DATA_W      = 32;
  localparam int WIDTH_W     = 32;
  localparam int CH_IDX_W    = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [PIN_W-1:0] pin_t;

endpackage

// File: sv/multi_channel_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// multi_channel_pulse_width_capture: eight channel pulse width capture
// samples 40 pin levels with a timestamp and reports pulse widths on
// falling edges of each channel's configured pin
// ----------------------------------------------------------------------------
// result path: the edge taking a sample writes its word to the edge queue,
// the serializer loads it when free and shows one result word per cycle while
// pop is held; one sample is taken per cycle while full is low
// full rises only when the 4-word edge queue holds samples with falling edges
// reset (synchronous, rst_n low): pin map, previous levels, start times,
// queue and serializer are cleared
module multi_channel_pulse_width_capture #(
  parameter int CHANNELS  = mcpwc_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = mcpwc_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample side
  input  logic                               push,
  output logic                               full,
  input  logic [31:0]                        in_pins_low_word,
  input  logic [7:0]                         in_pins_high_word,
  input  logic [31:0]                        in_timestamp,
  // result side
  output logic                               empty,
  input  logic                               pop,
  output logic [mcpwc_pkg::CH_IDX_W-1:0]     out_channel,
  output logic [mcpwc_pkg::WIDTH_W-1:0]      out_pulse_width,
  output logic                               out_last,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcpwc_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [mcpwc_pkg::DATA_W-1:0]       pwdata,
  output logic [mcpwc_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);
  import mcpwc_pkg::*;

  // timestamp input is 32 bits, so wider time counters give the same widths
  localparam int TW      = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int Q_WORD  = CHANNELS + CHANNELS * WIDTH_W;

  // pin map registers, one per channel slot, at byte address 4*i
  pin_t [NUM_REGS-1:0]              pin_cfg_r;
  logic [REG_IDX_W-1:0]             reg_idx;
  logic                             cfg_wr;

  // sample accept
  logic                             accept;

  // classifier to queue
  logic                             ev_push;
  logic [CHANNELS-1:0]              ev_fall;
  logic [CHANNELS-1:0][WIDTH_W-1:0] ev_width;

  // queue to serializer
  logic [Q_WORD-1:0]                q_rdata;
  logic                             q_valid;
  logic                             q_full;
  logic                             q_pop;
  logic [CHANNELS-1:0]              q_fall;
  logic [CHANNELS-1:0][WIDTH_W-1:0] q_width;

  // register port: always ready, write on access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = DATA_W'(pin_cfg_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_cfg_r <= '0;
    end else if (cfg_wr) begin
      pin_cfg_r[reg_idx] <= pwdata[PIN_W-1:0];
    end
  end

  // a sample is held off only when the edge queue has no room
  assign full   = q_full;
  assign accept = push & ~q_full;

  mcpwc_front #(
    .CHANNELS (CHANNELS),
    .TW       (TW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept_i   (accept),
    .pins_lo_i  (in_pins_low_word),
    .pins_hi_i  (in_pins_high_word),
    .now_i      (in_timestamp[TW-1:0]),
    .pin_cfg_i  (pin_cfg_r[CHANNELS-1:0]),
    .ev_push_o  (ev_push),
    .ev_fall_o  (ev_fall),
    .ev_width_o (ev_width)
  );

  // only samples with at least one falling edge take a queue slot
  mcpwc_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .WORD_W (Q_WORD)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (ev_push),
    .wdata_i ({ev_fall, ev_width}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  assign {q_fall, q_width} = q_rdata;

  // serializer holds the word being shown, so the front keeps taking samples
  mcpwc_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid_i     (q_valid),
    .q_fall_i      (q_fall),
    .q_width_i     (q_width),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_channel_o (out_channel),
    .out_width_o   (out_pulse_width),
    .out_last_o    (out_last)
  );

endmodule

// File: sv/mcpwc_front.sv
// ----------------------------------------------------------------------------
// mcpwc_front: sample classifier
// finds rising and falling edges per channel, keeps pulse start times and
// hands a falling-edge word (channel mask plus widths) to the queue
// ----------------------------------------------------------------------------
module mcpwc_front #(
  parameter int CHANNELS = 8,
  parameter int TW       = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept_i,
  input  logic [31:0]                          pins_lo_i,
  input  logic [7:0]                           pins_hi_i,
  input  logic [TW-1:0]                        now_i,
  input  mcpwc_pkg::pin_t [CHANNELS-1:0]       pin_cfg_i,
  output logic                                 ev_push_o,
  output logic [CHANNELS-1:0]                  ev_fall_o,
  output logic [CHANNELS-1:0][mcpwc_pkg::WIDTH_W-1:0] ev_width_o
);
  import mcpwc_pkg::*;

  logic [PIN_COUNT-1:0] prev_r;
  logic [TW-1:0]        start_r [CHANNELS];
  logic [PIN_COUNT-1:0] levels;
  logic [PIN_COUNT-1:0] changed;
  logic [CHANNELS-1:0]  rise;
  logic [CHANNELS-1:0]  fall;

  assign levels  = {pins_hi_i, pins_lo_i};
  assign changed = levels ^ prev_r;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      logic       valid_pin;
      logic       lvl;
      logic       chg;
      logic [TW-1:0] diff;
      valid_pin = pin_cfg_i[c] < PIN_W'(PIN_COUNT);
      lvl  = valid_pin ? levels[pin_cfg_i[c]]  : 1'b0;
      chg  = valid_pin ? changed[pin_cfg_i[c]] : 1'b0;
      rise[c] = chg & lvl;
      fall[c] = chg & ~lvl;
      // modulo subtraction handles timer wrap
      diff = now_i - start_r[c];
      ev_width_o[c] = WIDTH_W'(diff);
    end
  end

  assign ev_fall_o = fall;
  assign ev_push_o = accept_i & (|fall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      for (int c = 0; c < CHANNELS; c++) start_r[c] <= '0;
    end else if (accept_i) begin
      prev_r <= levels;
      for (int c = 0; c < CHANNELS; c++) begin
        if (rise[c]) start_r[c] <= now_i;
      end
    end
  end

endmodule

// File: sv/mcpwc_queue.sv
// ----------------------------------------------------------------------------
// mcpwc_queue: short word queue between classifier and serializer
// register-based fifo, head word visible while not empty
// ----------------------------------------------------------------------------
module mcpwc_queue #(
  parameter int DEPTH = 4,
  parameter int WORD_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [WORD_W-1:0] rdata_o,
  output logic              valid_o,
  output logic              full_o
);
  import mcpwc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  assign rdata_o = mem_r[rd_ptr_r];
  assign valid_o = count_r != '0;
  assign full_o  = count_r == CNT_W'(DEPTH);

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop_i) count_nxt = count_r + 1'b1;
    if (pop_i && !push_i) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= wdata_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && count_r == CNT_W'(DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && count_r == '0))
    else $error("pop from empty queue");

endmodule

// File: sv/mcpwc_back.sv
// ----------------------------------------------------------------------------
// mcpwc_back: result serializer
// takes one queued word and gives one result per falling channel,
// lowest channel first, marking the last one
// ----------------------------------------------------------------------------
module mcpwc_back #(
  parameter int CHANNELS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        q_valid_i,
  input  logic [CHANNELS-1:0]                         q_fall_i,
  input  logic [CHANNELS-1:0][mcpwc_pkg::WIDTH_W-1:0] q_width_i,
  output logic                                        q_pop_o,
  input  logic                                        pop_i,
  output logic                                        empty_o,
  output logic [mcpwc_pkg::CH_IDX_W-1:0]              out_channel_o,
  output logic [mcpwc_pkg::WIDTH_W-1:0]               out_width_o,
  output logic                                        out_last_o
);
  import mcpwc_pkg::*;

  logic                                busy_r;
  logic [CHANNELS-1:0]                 mask_r;
  logic [CHANNELS-1:0]                 mask_nxt;
  logic [CHANNELS-1:0][WIDTH_W-1:0]    width_r;
  logic                                take;
  logic                                done;

  // lowest pending channel
  always_comb begin
    out_channel_o = '0;
    out_width_o   = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (mask_r[c]) begin
        out_channel_o = CH_IDX_W'(c);
        out_width_o   = width_r[c];
      end
    end
  end

  assign mask_nxt   = mask_r & (mask_r - 1'b1);
  assign out_last_o = mask_nxt == '0;
  assign empty_o    = ~busy_r;
  assign take       = busy_r & pop_i;
  assign done       = take & out_last_o;
  assign q_pop_o    = q_valid_i & (~busy_r | done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mask_r <= '0;
    end else if (q_pop_o) begin
      busy_r <= 1'b1;
      mask_r <= q_fall_i;
    end else if (take) begin
      mask_r <= mask_nxt;
      if (out_last_o) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) width_r <= q_width_i;
  end

  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (mask_r != '0))
    else $error("serializer busy with no pending channel");

  a_not_last_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last_o) |=> (busy_r && $countones(mask_r) == $countones($past(mask_r)) - 1))
    else $error("non-final word did not leave the rest pending");

  a_queue_word_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_o |-> (q_fall_i != '0))
    else $error("queued word without a falling channel");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multi channel pulse width capture block
// drives pin samples through the push side, pops capture words with random
// stalls, reprograms the pin map between phases and compares every word
// against a scoreboard that tracks levels, start times and the pin map
// ----------------------------------------------------------------------------
module tb_top;
  import mcpwc_pkg::*;

  localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES  = 120;   // long receiver hold-off to fill the queue
  localparam int SETTLE       = 8;     // settle time after the last pending word
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 40;

  // one capture word as the block emits it
  typedef struct packed {
    logic [CH_IDX_W-1:0] channel;
    logic [WIDTH_W-1:0]  width;
    logic                last;
  } capture_t;

  // tracks pin map, previous levels and pulse starts; holds pending words
  class pulse_scoreboard;
    pin_t               pin_map [NUM_REGS];
    logic [39:0]        prev_levels;
    logic [WIDTH_W-1:0] rise_time [NUM_REGS];
    capture_t           pending_q [$];
    int                 errors;
    int                 n_words;

    function new();
      foreach (pin_map[i]) begin
        pin_map[i]   = '0;
        rise_time[i] = '0;
      end
      prev_levels = '0;
      errors      = 0;
      n_words     = 0;
    endfunction

    function void set_pin(int idx, pin_t value);
      if (idx < NUM_REGS) pin_map[idx] = value;
    endfunction

    // a sample was accepted: update state and queue the words it causes
    function void note_sample(logic [31:0] lo, logic [7:0] hi, logic [31:0] ts);
      logic [39:0] levels;
      logic [39:0] changed;
      capture_t    word;
      int          first_new;
      levels    = {hi, lo};
      changed   = levels ^ prev_levels;
      first_new = pending_q.size();
      prev_levels = levels;
      for (int ch = 0; ch < NUM_REGS; ch++) begin
        // pins past the last one never toggle
        if (pin_map[ch] >= PIN_COUNT) continue;
        if (!changed[pin_map[ch]]) continue;
        if (levels[pin_map[ch]]) begin
          rise_time[ch] = ts;
        end else begin
          word.channel = CH_IDX_W'(ch);
          word.width   = ts - rise_time[ch];  // wraps with the timer
          word.last    = 1'b0;
          pending_q.push_back(word);
        end
      end
      if (pending_q.size() > first_new) pending_q[pending_q.size()-1].last = 1'b1;
    endfunction

    function void check_word(logic [CH_IDX_W-1:0] ch, logic [WIDTH_W-1:0] width,
                             logic last);
      capture_t want;
      n_words++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word channel=%0d width=%0h last=%0b",
                 $time, ch, width, last);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (ch !== want.channel) begin
        $display("%0t: channel mismatch expected %0d actual %0d", $time, want.channel, ch);
        errors++;
      end
      if (width !== want.width) begin
        $display("%0t: pulse_width mismatch (channel %0d) expected %0h actual %0h",
                 $time, want.channel, want.width, width);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch (channel %0d) expected %0b actual %0b",
                 $time, want.channel, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  // dut signals
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [31:0]           in_pins_low_word;
  logic [7:0]            in_pins_high_word;
  logic [31:0]           in_timestamp;
  logic                  empty;
  logic                  pop;
  logic [CH_IDX_W-1:0]   out_channel;
  logic [WIDTH_W-1:0]    out_pulse_width;
  logic                  out_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  multi_channel_pulse_width_capture u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_pins_low_word (in_pins_low_word),
    .in_pins_high_word(in_pins_high_word),
    .in_timestamp     (in_timestamp),
    .empty            (empty),
    .pop              (pop),
    .out_channel      (out_channel),
    .out_pulse_width  (out_pulse_width),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pulse_scoreboard sb = new();

  // bench-side copy of the pin map, used to steer stimulus toward real edges
  pin_t        cfg_pins [NUM_REGS];
  logic [39:0] cur_levels;
  logic [31:0] cur_ts;
  int          burst_left;
  int          quiet_cycles;
  int          n_samples;
  int          n_writes;
  int          n_settings;
  int          n_full_cycles;
  bit          hold_req;

  // ---------------------------------------------------------------------------
  // monitor: every handshake is seen here, on values from before the edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (push && full) n_full_cycles <= n_full_cycles + 1;
      if (push && !full) begin
        sb.note_sample(in_pins_low_word, in_pins_high_word, in_timestamp);
        n_samples <= n_samples + 1;
        moved     = 1'b1;
      end
      if (pop && !empty) begin
        sb.check_word(out_channel, out_pulse_width, out_last);
        moved = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        sb.set_pin(int'(paddr[REG_ADDR_W-1:2]), pin_t'(pwdata));
        n_writes <= n_writes + 1;
        moved    = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog: too long with no word moving on any port
  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: stretches of always-pop, random pop, sparse pop and short stalls,
  // plus one long hold-off on request so the edge queue backs up into full
  // ---------------------------------------------------------------------------
  initial begin
    int stretch;
    int mode;
    pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stretch = $urandom_range(1, 40);
      mode    = $urandom_range(0, 3);
      for (int k = 0; k < stretch; k++) begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= $urandom_range(0, 1);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------

  // offer one sample and hold it until the block takes it
  task automatic send_sample(input logic [31:0] lo, input logic [7:0] hi,
                             input logic [31:0] ts);
    push              <= 1'b1;
    in_pins_low_word  <= lo;
    in_pins_high_word <= hi;
    in_timestamp      <= ts;
    cur_levels = {hi, lo};
    cur_ts     = ts;
    @(posedge clk);
    while (full) @(posedge clk);
    // burst bookkeeping: at the end of a burst drop push for a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 15);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering, wait for every pending word, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write the whole pin map, setup and access phase per register
  task automatic program_pins(input pin_t map [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_ADDR_W'(i * 4);
      pwdata  <= DATA_W'(map[i]);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      cfg_pins[i] = map[i];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  // next sample in a random phase: mostly pulses on the mapped pins with
  // advancing time, sometimes a fully random sample with a random timestamp
  task automatic send_random_sample();
    logic [39:0] next;
    logic [31:0] ts;
    next = cur_levels;
    if ($urandom_range(0, 9) == 0) begin
      next = {8'($urandom_range(0, 255)), 32'($urandom())};
      ts   = $urandom();
    end else begin
      foreach (cfg_pins[ch])
        if (cfg_pins[ch] < PIN_COUNT && $urandom_range(0, 3) == 0)
          next[cfg_pins[ch]] = ~next[cfg_pins[ch]];
      // sparse chatter on the other pins
      next ^= {8'($urandom & $urandom & $urandom), 32'($urandom & $urandom & $urandom)};
      ts = cur_ts + (($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(1, 3000));
    end
    send_sample(next[31:0], next[39:32], ts);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    pin_t map [NUM_REGS];

    rst_n             = 1'b0;
    push              = 1'b0;
    in_pins_low_word  = '0;
    in_pins_high_word = '0;
    in_timestamp      = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    hold_req          = 1'b0;
    burst_left        = 0;
    quiet_cycles      = 0;
    n_samples         = 0;
    n_writes          = 0;
    n_settings        = 0;
    n_full_cycles     = 0;
    cur_levels        = '0;
    cur_ts            = '0;
    foreach (cfg_pins[i]) cfg_pins[i] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset map puts every channel on pin 0; raise pin 5 so a later channel
    // mapped there sees a fall with no rise and measures from the reset start
    send_sample(32'h0000_0020, 8'h00, 32'd50);
    drain();

    // extremes: pin 0, pin 39, two missing pins, word boundary pins,
    // and two channels sharing pin 5
    map = '{6'd0, 6'd39, 6'd40, 6'd63, 6'd31, 6'd32, 6'd5, 6'd5};
    program_pins(map);
    send_sample(32'h0000_0000, 8'h00, 32'd1000);         // ch6/ch7 fall, start 0
    send_sample(32'h0000_0000, 8'h80, 32'd100);          // pin 39 rises
    send_sample(32'h8000_0021, 8'h81, 32'd200);          // pins 0,5,31,32 rise
    send_sample(32'h0000_0000, 8'h00, 32'd0);            // six falls, wrapped widths
    send_sample(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);    // everything high
    send_sample(32'h7FFF_FFFF, 8'h7F, 32'h0000_0000);    // pins 31 and 39 fall
    send_sample(32'h1234_5678, 8'h5A, 32'hDEAD_BEEF);
    send_sample(32'h1234_5678, 8'h5A, 32'hDEAD_BEF0);    // no change at all
    send_sample(32'h0000_0000, 8'h00, 32'h8000_0000);
    drain();

    // every channel on pin 0 again: one pulse gives eight words
    map = '{default: 6'd0};
    program_pins(map);
    send_sample(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFF0);
    send_sample(32'h0000_0000, 8'h00, 32'h0000_0010);    // width wraps to 0x20
    send_sample(32'h0000_0001, 8'h00, 32'h0000_0011);
    send_sample(32'h0000_0000, 8'h00, 32'h0000_0011);    // zero width
    drain();

    // random phases, a fresh pin map each time
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      foreach (map[i]) begin
        if (ph == 0)
          map[i] = pin_t'(32 + i);                       // high word pins
        else if ($urandom_range(0, 7) == 0)
          map[i] = pin_t'($urandom_range(PIN_COUNT, 63));
        else
          map[i] = pin_t'($urandom_range(0, PIN_COUNT - 1));
      end
      program_pins(map);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 5) hold_req = 1'b1;          // back the queue up once
        send_random_sample();
      end
      drain();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("run covered %0d samples and %0d capture words over %0d pin maps",
             n_samples, sb.n_words, n_settings);
    $display("%0d register writes, input stalled by full for %0d cycles",
             n_writes, n_full_cycles);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
sv/mcpwc_pkg.sv
sv/mcpwc_front.sv
sv/mcpwc_queue.sv
sv/mcpwc_back.sv
sv/multi_channel_pulse_width_capture.sv
test/tb_top.sv
